// ===== rtl/ptnt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptnt_pkg: shared types and constants
// Configuration layout, register indexes and queue item format of the
// pitch-to-note tracker.
// ----------------------------------------------------------------------------
package ptnt_pkg;

    localparam int unsigned LOG_TABLE_ENTRIES = 64;

    localparam int unsigned FREQ_W   = 17;
    localparam int unsigned CONF_W   = 16;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_TOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF   = 3'd5;

    // command codes
    localparam logic CMD_PITCH = 1'b0;
    localparam logic CMD_VOICE = 1'b1;

    typedef struct packed {
        logic [15:0] conf_thr;
        logic [14:0] max_jump;
        logic [16:0] smooth;
        logic [8:0]  note_tol;
        logic [3:0]  stable;
        logic [5:0]  note_off;
    } cfg_t;

    typedef enum logic [1:0] {
        K_PITCH,
        K_REJECT,
        K_VOICED,
        K_UNVOICED
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [FREQ_W-1:0] freq;
    } item_t;

endpackage

// ===== rtl/ptnt_front.sv =====
// ----------------------------------------------------------------------------
// ptnt_front: frame intake
// Accepts frames, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ptnt_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ptnt_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_command,
    input  logic [ptnt_pkg::FREQ_W-1:0]    in_freq,
    input  logic [ptnt_pkg::CONF_W-1:0]    in_conf,
    input  logic                           in_voiced,
    output logic                           q_valid,
    input  logic                           q_pop,
    output ptnt_pkg::item_t                q_item
);

    ptnt_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    ptnt_pkg::item_t cls;
    logic            push;

    // classify the frame
    always_comb begin
        cls.freq = in_freq;
        if (in_command == ptnt_pkg::CMD_VOICE) begin
            cls.kind = in_voiced ? ptnt_pkg::K_VOICED : ptnt_pkg::K_UNVOICED;
        end else if (in_freq == '0 || in_conf < cfg.conf_thr) begin
            cls.kind = ptnt_pkg::K_REJECT;
        end else begin
            cls.kind = ptnt_pkg::K_PITCH;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== rtl/ptnt_back.sv =====
// ----------------------------------------------------------------------------
// ptnt_back: tracking sequencer
// Smooths frequency, converts to pitch by table log2 on one shared
// multiplier, and runs the note hold and silence logic.
// ----------------------------------------------------------------------------
module ptnt_back #(
    parameter int unsigned LOG_TABLE_ENTRIES = ptnt_pkg::LOG_TABLE_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ptnt_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  ptnt_pkg::item_t                q_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ptnt_pkg::NOTE_W-1:0]    out_note,
    output logic                           out_active,
    output logic                           out_off
);

    localparam int unsigned IDX_W  = $clog2(LOG_TABLE_ENTRIES);
    localparam int unsigned TAB_W  = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int unsigned PW     = 20;

    function automatic logic [16:0] frac_log(input int unsigned i);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_TABLE_ENTRIES));
        r = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r[0] = 1'b1;
            end
        end
        return {1'b0, r};
    endfunction

    function automatic logic [20:0] log2_const(input int unsigned f);
        int unsigned e;
        longint unsigned m, p, idx, rem, a, b;
        e = 0;
        for (int k = 0; k < 31; k++) begin
            if ((f >> (k + 1)) != 0) e = k + 1;
        end
        m   = ((longint'(f) << 16) >> e) - 65536;
        p   = m * LOG_TABLE_ENTRIES;
        idx = p >> 16;
        rem = p & 64'hFFFF;
        a   = frac_log(int'(idx));
        b   = (idx + 1 == LOG_TABLE_ENTRIES) ? 64'd65536 : 64'(frac_log(int'(idx + 1)));
        return 21'((longint'(e) << 16) + a + (((b - a) * rem) >> 16));
    endfunction

    localparam logic [20:0] LOG_REF = log2_const(16 * 440);

    logic [16:0] log_tab [LOG_TABLE_ENTRIES + 1];

    for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_tab
        assign log_tab[g] = frac_log(g);
    end
    assign log_tab[LOG_TABLE_ENTRIES] = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE, S_L0, S_L1, S_L2, S_SM0, S_SM1, S_SM2, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        P_NEW, P_OLD, P_FINAL
    } purpose_t;

    state_t      state_reg;
    purpose_t    purp_reg;
    logic [16:0] f_reg, smooth_reg;
    logic [33:0] acc_reg, prod_reg;
    logic [4:0]  e_reg;
    logic [16:0] a_reg;
    logic signed [PW-1:0] pnew_reg;
    logic [6:0]  held_reg, cand_reg;
    logic        held_v_reg, cand_v_reg;
    logic [3:0]  cnt_reg;
    logic [5:0]  sil_reg;
    logic        ov_reg, oact_reg, ooff_reg;
    logic [6:0]  onote_reg;

    // combinational datapath
    logic [16:0] op_f;
    logic [4:0]  e_c;
    logic [32:0] shifted;
    logic [15:0] m_c;
    logic [IDX_W-1:0] idx_c;
    logic [TAB_W-1:0] ia, ib;
    logic [16:0] ta, tb;
    logic [16:0] mul_a, mul_b;
    logic [16:0] alpha, one_m_alpha;
    logic [20:0] log_c;
    logic signed [21:0] dlog;
    logic signed [33:0] scaled;
    logic signed [PW-1:0] pitch_c, djump, dhold;
    logic signed [PW-1:0] nraw;
    logic [6:0]  note_c;
    logic [34:0] sm_sum;

    always_comb begin
        op_f = (purp_reg == P_NEW) ? f_reg : smooth_reg;
        e_c  = '0;
        for (int k = 1; k < 17; k++) begin
            if (op_f[k]) e_c = 5'(k);
        end
        shifted = ({16'd0, op_f} << 16) >> e_c;
        m_c     = shifted[15:0];
        idx_c   = prod_reg[16 +: IDX_W];
        ia      = TAB_W'(idx_c);
        ib      = ia + TAB_W'(1);
        ta      = log_tab[ia];
        tb      = log_tab[ib];
        alpha       = cfg.smooth[16] ? 17'd65536 : cfg.smooth;
        one_m_alpha = 17'd65536 - alpha;
        case (state_reg)
            S_L0: begin
                mul_a = {1'b0, m_c};
                mul_b = 17'(LOG_TABLE_ENTRIES);
            end
            S_L1: begin
                mul_a = tb - ta;
                mul_b = {1'b0, prod_reg[15:0]};
            end
            S_SM0: begin
                mul_a = smooth_reg;
                mul_b = one_m_alpha;
            end
            S_SM1: begin
                mul_a = f_reg;
                mul_b = alpha;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        log_c   = {e_reg, 16'd0} + 21'(a_reg) + 21'(prod_reg[32:16]);
        dlog    = $signed({1'b0, log_c}) - $signed({1'b0, LOG_REF});
        scaled  = (34'(dlog) <<< 11) + (34'(dlog) <<< 10) + 34'sd32768;
        pitch_c = PW'(scaled >>> 16) + PW'(69 * 256);
        djump   = pnew_reg - pitch_c;
        if (djump < 0) djump = -djump;
        dhold   = pitch_c - $signed({{(PW-15){1'b0}}, held_reg, 8'd0});
        if (dhold < 0) dhold = -dhold;
        nraw    = (pitch_c + PW'(128)) >>> 8;
        if (nraw < 0) begin
            note_c = 7'd0;
        end else if (nraw > PW'(127)) begin
            note_c = 7'd127;
        end else begin
            note_c = nraw[6:0];
        end
        sm_sum = 35'(acc_reg) + 35'(prod_reg) + 35'd32768;
    end

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign out_valid  = ov_reg;
    assign out_note   = onote_reg;
    assign out_active = oact_reg;
    assign out_off    = ooff_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            purp_reg   <= P_NEW;
            held_reg   <= '0;
            held_v_reg <= 1'b0;
            cand_reg   <= '0;
            cand_v_reg <= 1'b0;
            cnt_reg    <= '0;
            smooth_reg <= '0;
            sil_reg    <= '0;
            ov_reg     <= 1'b0;
        end else begin
            if (ov_reg && out_ready && state_reg != S_OUT) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        f_reg     <= q_item.freq;
                        state_reg <= S_OUT;
                        case (q_item.kind)
                            ptnt_pkg::K_VOICED: sil_reg <= '0;
                            ptnt_pkg::K_UNVOICED: begin
                                if (sil_reg != 6'd63) sil_reg <= sil_reg + 6'd1;
                                cand_reg <= '0; cand_v_reg <= 1'b0; cnt_reg <= '0;
                            end
                            ptnt_pkg::K_REJECT: begin
                                cand_reg <= '0; cand_v_reg <= 1'b0; cnt_reg <= '0;
                            end
                            ptnt_pkg::K_PITCH: begin
                                state_reg <= S_L0;
                                if (smooth_reg == '0) begin
                                    smooth_reg <= q_item.freq;
                                    sil_reg    <= '0;
                                    purp_reg   <= P_FINAL;
                                end else begin
                                    purp_reg <= P_NEW;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_L0: begin
                    e_reg     <= e_c;
                    state_reg <= S_L1;
                end
                S_L1: begin
                    a_reg     <= ta;
                    state_reg <= S_L2;
                end
                S_L2: begin
                    case (purp_reg)
                        P_NEW: begin
                            pnew_reg  <= pitch_c;
                            purp_reg  <= P_OLD;
                            state_reg <= S_L0;
                        end
                        P_OLD: begin
                            if (djump > $signed({{(PW-15){1'b0}}, cfg.max_jump})) begin
                                cand_reg <= '0; cand_v_reg <= 1'b0; cnt_reg <= '0;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_SM0;
                            end
                        end
                        default: begin
                            state_reg <= S_OUT;
                            if (held_v_reg &&
                                dhold < $signed({{(PW-9){1'b0}}, cfg.note_tol})) begin
                                cand_reg <= '0; cand_v_reg <= 1'b0; cnt_reg <= '0;
                            end else begin
                                logic [3:0] c;
                                c = (cand_v_reg && cand_reg == note_c)
                                    ? ((cnt_reg != 4'd15) ? cnt_reg + 4'd1 : cnt_reg)
                                    : 4'd1;
                                if (c >= cfg.stable) begin
                                    held_reg   <= note_c;
                                    held_v_reg <= 1'b1;
                                    cand_reg <= '0; cand_v_reg <= 1'b0; cnt_reg <= '0;
                                end else begin
                                    cand_reg <= note_c; cand_v_reg <= 1'b1; cnt_reg <= c;
                                end
                            end
                        end
                    endcase
                end
                S_SM0: state_reg <= S_SM1;
                S_SM1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SM2;
                end
                S_SM2: begin
                    smooth_reg <= sm_sum[32:16];
                    sil_reg    <= '0;
                    purp_reg   <= P_FINAL;
                    state_reg  <= S_L0;
                end
                S_OUT: begin
                    if (!ov_reg || out_ready) begin
                        ov_reg    <= 1'b1;
                        onote_reg <= held_v_reg ? held_reg : 7'd0;
                        oact_reg  <= held_v_reg;
                        ooff_reg  <= held_v_reg && (sil_reg >= cfg.note_off);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pitch_to_note_tracker.sv =====
// ----------------------------------------------------------------------------
// pitch_to_note_tracker: pitch frame to MIDI note tracker
// Turns pitch and voice-state frames into a held note with note-off.
// ----------------------------------------------------------------------------
// One result leaves on the m_ channel for every frame taken on the s_
// channel, in order. Voice-state frames and rejected pitch frames pass the
// sequencer straight to its output state; an accepted pitch frame runs up to
// three log2 conversions and two smoothing products through one shared
// 17x17 multiplier. A two-entry queue stands in front of the sequencer and a
// result register behind it, so frames are taken while a result waits.
// The user must write configuration through cfg_* only while the block is
// idle; the block itself does not enforce this. Index 0 confidence
// threshold, 1 max jump, 2 smoothing factor, 3 note tolerance, 4 stable
// frames, 5 note-off frames; other indexes drop.
// ----------------------------------------------------------------------------
module pitch_to_note_tracker #(
    parameter int unsigned LOG_TABLE_ENTRIES = ptnt_pkg::LOG_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frequency[16:0], confidence[32:17], voiced[33]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // note[6:0], note_active[7], note_off[8]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    ptnt_pkg::cfg_t  cfg_reg;
    ptnt_pkg::item_t q_item;
    logic            q_valid, q_pop;
    logic [6:0]      note;
    logic            active, off;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conf_thr <= 16'd32768;
            cfg_reg.max_jump <= 15'd3072;
            cfg_reg.smooth   <= 17'd19661;
            cfg_reg.note_tol <= 9'd128;
            cfg_reg.stable   <= 4'd3;
            cfg_reg.note_off <= 6'd9;
        end else if (cfg_valid) begin
            case (cfg_index)
                ptnt_pkg::REG_CONF_THR: cfg_reg.conf_thr <= cfg_data[15:0];
                ptnt_pkg::REG_MAX_JUMP: cfg_reg.max_jump <= cfg_data[14:0];
                ptnt_pkg::REG_SMOOTH:   cfg_reg.smooth   <= cfg_data;
                ptnt_pkg::REG_NOTE_TOL: cfg_reg.note_tol <= cfg_data[8:0];
                ptnt_pkg::REG_STABLE:   cfg_reg.stable   <= cfg_data[3:0];
                ptnt_pkg::REG_NOTE_OFF: cfg_reg.note_off <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // intake and classification
    ptnt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_freq    (s_tdata[16:0]),
        .in_conf    (s_tdata[32:17]),
        .in_voiced  (s_tdata[33]),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    // tracking sequencer and result register
    ptnt_back #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_note   (note),
        .out_active (active),
        .out_off    (off)
    );

    assign m_tdata = {7'd0, off, active, note};

endmodule

// ===== tb/pitch_to_note_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_to_note_tracker_test: self-checking bench for the note tracker
// Streams pitch and voice-state frames through the block. An internal model
// follows the held note, and a checker compares every result in order.
// ----------------------------------------------------------------------------
module pitch_to_note_tracker_test;

    typedef struct packed {
        logic [ptnt_pkg::NOTE_W-1:0] note;
        logic                        active;
        logic                        off;
    } note_state_t;

    // Note tracker model and in-order checker of results
    class note_scoreboard;
        int unsigned log_tab[ptnt_pkg::LOG_TABLE_ENTRIES+1];
        longint      log_ref;
        int unsigned thr, jump, alpha, tol, stable, offn;
        int unsigned held_note, held_valid, cand_note, cand_valid, cand_cnt;
        int unsigned sm_freq, silence;
        note_state_t pending[$];
        int          errors;

        function new();
            longint unsigned x;
            int unsigned r;
            for (int i = 0; i < ptnt_pkg::LOG_TABLE_ENTRIES; i++) begin
                x = (64'd1 << 30) + ((longint'(i) << 30) / ptnt_pkg::LOG_TABLE_ENTRIES);
                r = 0;
                for (int k = 0; k < 16; k++) begin
                    x = (x * x) >> 30;
                    r = r << 1;
                    if (x >= (64'd2 << 30)) begin
                        x = x >> 1;
                        r = r | 1;
                    end
                end
                log_tab[i] = r;
            end
            log_tab[ptnt_pkg::LOG_TABLE_ENTRIES] = 65536;
            log_ref = log2_q16(16 * 440);
            thr = 32768; jump = 3072; alpha = 19661; tol = 128; stable = 3; offn = 9;
            held_note = 0; held_valid = 0; sm_freq = 0; silence = 0;
            drop_cand();
            errors = 0;
        endfunction

        function longint log2_q16(int unsigned f);
            int unsigned e, idx, rem;
            longint unsigned m, p, a, b;
            e = 0;
            while (e < 31 && (f >> (e + 1)) != 0) e++;
            m = ((longint'(f) << 16) >> e) - 65536;
            p = m * ptnt_pkg::LOG_TABLE_ENTRIES;
            idx = 32'(p >> 16);
            rem = 32'(p & 16'hFFFF);
            if (idx > ptnt_pkg::LOG_TABLE_ENTRIES - 1) idx = ptnt_pkg::LOG_TABLE_ENTRIES - 1;
            a = log_tab[idx];
            b = log_tab[idx+1];
            return (longint'(e) << 16) + longint'(a + (((b - a) * rem) >> 16));
        endfunction

        function longint fdiv(longint v, longint d);
            if (v >= 0) return v / d;
            return -((-v + d - 1) / d);
        endfunction

        function longint pitch_of(int unsigned f);
            return 69 * 256 + fdiv((log2_q16(f) - log_ref) * 3072 + 32768, 65536);
        endfunction

        function void drop_cand();
            cand_note = 0; cand_valid = 0; cand_cnt = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] v);
            case (idx)
                ptnt_pkg::REG_CONF_THR: thr = v[15:0];
                ptnt_pkg::REG_MAX_JUMP: jump = v[14:0];
                ptnt_pkg::REG_SMOOTH:   alpha = v;
                ptnt_pkg::REG_NOTE_TOL: tol = v[8:0];
                ptnt_pkg::REG_STABLE:   stable = v[3:0];
                ptnt_pkg::REG_NOTE_OFF: offn = v[5:0];
                default: ;
            endcase
        endfunction

        function void pitch_frame(int unsigned f, int unsigned conf);
            longint p, d, n;
            longint unsigned a;
            if (f == 0 || conf < thr) begin
                drop_cand();
                return;
            end
            if (sm_freq == 0) begin
                sm_freq = f;
            end else begin
                a = (alpha > 65536) ? 65536 : alpha;
                d = pitch_of(f) - pitch_of(sm_freq);
                if (d < 0) d = -d;
                if (d > jump) begin
                    drop_cand();
                    return;
                end
                sm_freq = 32'(((longint'(sm_freq) * (65536 - a) + longint'(f) * a + 32768)
                               >> 16) & 17'h1FFFF);
            end
            silence = 0;
            p = pitch_of(sm_freq);
            n = fdiv(p + 128, 256);
            if (n < 0) n = 0;
            if (n > 127) n = 127;
            if (held_valid) begin
                d = p - longint'(held_note) * 256;
                if (d < 0) d = -d;
                if (d < tol) begin
                    drop_cand();
                    return;
                end
            end
            if (cand_valid && cand_note == n) begin
                if (cand_cnt < 15) cand_cnt++;
            end else begin
                cand_note = 32'(n); cand_valid = 1; cand_cnt = 1;
            end
            if (cand_cnt >= stable) begin
                held_note = 32'(n); held_valid = 1;
                drop_cand();
            end
        endfunction

        // note an accepted frame and queue the result it must produce
        function void note_frame(logic cmd, int unsigned f, int unsigned conf, logic voiced);
            note_state_t r;
            if (cmd == ptnt_pkg::CMD_PITCH) pitch_frame(f, conf);
            else if (voiced) silence = 0;
            else begin
                if (silence < 63) silence++;
                drop_cand();
            end
            r.note = held_valid ? held_note[6:0] : '0;
            r.active = held_valid[0];
            r.off = held_valid != 0 && silence >= offn;
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            note_state_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[6:0] !== e.note || data[7] !== e.active || data[8] !== e.off
                    || data[15:9] !== '0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected note %0d act %b off %b, got %h",
                             e.note, e.active, e.off, data);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0, s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid, m_tready = 0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 0, cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    note_scoreboard board = new();
    bit          calm;        // no idling on either side
    bit          hold_sink;   // long receiver hold-off
    int          cycles = 0;
    int unsigned base_freq = 7040;

    pitch_to_note_tracker dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // watchdog: the run ends on a generous cycle count
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // check each result transfer at the rising edge
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_sink) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 15);
    end

    initial begin
        hold_sink = 0;
        wait (aresetn);
        repeat (50) @(negedge aclk);
        hold_sink = 1;
        repeat (200) @(negedge aclk);
        hold_sink = 0;
    end

    // offer one frame; hold until the transfer happens
    task automatic send_frame(logic cmd, int unsigned f, int unsigned conf, logic voiced);
        while (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, voiced, conf[15:0], f[16:0]};
        do @(posedge aclk); while (!s_tready);
        board.note_frame(cmd, f[16:0], conf[15:0], voiced);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drop the input, drain outstanding results, then let the sequencer settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // random frame mostly near a drifting base pitch
    task automatic random_frame();
        int unsigned k, f;
        k = $urandom_range(99);
        if (k < 70) begin
            if ($urandom_range(15) == 0) base_freq = $urandom_range(131071, 200);
            f = base_freq + $urandom_range(base_freq / 16) - base_freq / 32;
            if (f > 131071) f = 131071;
            send_frame(ptnt_pkg::CMD_PITCH, f, $urandom_range(65535, 30000), 1'b0);
        end else if (k < 85) begin
            send_frame(ptnt_pkg::CMD_VOICE, $urandom, $urandom, 1'($urandom_range(1)));
        end else begin
            send_frame(ptnt_pkg::CMD_PITCH, $urandom_range(131071), $urandom_range(65535),
                       1'($urandom_range(1)));
        end
    endtask

    initial begin
        calm = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, rejections, held note, silence run
        send_frame(ptnt_pkg::CMD_PITCH, 0, 65535, 1'b0);
        send_frame(ptnt_pkg::CMD_PITCH, 7040, 1000, 1'b0);
        send_frame(ptnt_pkg::CMD_PITCH, 131071, 65535, 1'b1);
        send_frame(ptnt_pkg::CMD_PITCH, 1, 65535, 1'b0);
        send_frame(ptnt_pkg::CMD_PITCH, 1, 65535, 1'b0);
        for (int i = 0; i < 4; i++) send_frame(ptnt_pkg::CMD_PITCH, 7040, 40000, 1'b0);
        send_frame(ptnt_pkg::CMD_PITCH, 100000, 65535, 1'b0);
        send_frame(ptnt_pkg::CMD_VOICE, 131071, 65535, 1'b1);
        for (int i = 0; i < 12; i++) send_frame(ptnt_pkg::CMD_VOICE, 0, 0, 1'b0);
        drain();

        // extreme settings, including invalid index and smoothing above unity
        write_reg(ptnt_pkg::REG_CONF_THR, 17'h1FFFF);
        write_reg(ptnt_pkg::REG_MAX_JUMP, 17'h1FFFF);
        write_reg(ptnt_pkg::REG_SMOOTH, 17'h1FFFF);
        write_reg(ptnt_pkg::REG_NOTE_TOL, 17'h1FFFF);
        write_reg(ptnt_pkg::REG_STABLE, 17'd0);
        write_reg(ptnt_pkg::REG_NOTE_OFF, 17'd1);
        write_reg(3'd7, 17'd5);
        for (int i = 0; i < 150; i++) random_frame();
        drain();

        write_reg(ptnt_pkg::REG_CONF_THR, 17'd19661);
        write_reg(ptnt_pkg::REG_MAX_JUMP, 17'd0);
        write_reg(ptnt_pkg::REG_SMOOTH, 17'd0);
        write_reg(ptnt_pkg::REG_NOTE_TOL, 17'd13);
        write_reg(ptnt_pkg::REG_STABLE, 17'd15);
        write_reg(ptnt_pkg::REG_NOTE_OFF, 17'd63);
        for (int i = 0; i < 150; i++) random_frame();
        drain();

        calm = 1;
        write_reg(ptnt_pkg::REG_CONF_THR, 17'd32768);
        write_reg(ptnt_pkg::REG_MAX_JUMP, 17'd24576);
        write_reg(ptnt_pkg::REG_SMOOTH, 17'd65536);
        write_reg(ptnt_pkg::REG_NOTE_TOL, 17'd128);
        write_reg(ptnt_pkg::REG_STABLE, 17'd1);
        write_reg(ptnt_pkg::REG_NOTE_OFF, 17'd44);
        for (int i = 0; i < 150; i++) random_frame();
        drain();

        calm = 0;
        for (int r = 0; r < 6; r++) begin
            write_reg(r[2:0], 17'($urandom_range(131071)));
        end
        write_reg(ptnt_pkg::REG_STABLE, 17'($urandom_range(10, 1)));
        write_reg(ptnt_pkg::REG_NOTE_OFF, 17'($urandom_range(44, 1)));
        for (int i = 0; i < 180; i++) random_frame();
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
